[hw/rtl/dsc_pkg.sv]
package dsc_pkg;

	localparam int WORD_SLOTS_DEF   = 16;
	localparam int MAX_WORD_LEN_DEF = 16;

	typedef enum logic [1:0] {
		CMD_WRITE_CHAR = 2'd0,
		CMD_START      = 2'd1,
		CMD_TEXT       = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SLOT,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/dictionary_segmentation_check_core.sv]
// Word-break checker. Load the dictionary with write-character beats (slot, character
// position, slot length, byte), send a start beat to clear the text, then send one text
// beat per byte; each beat returns one segmentable flag, 1 when all text since the start
// splits into dictionary words. Dictionary writes and start beats go from accept to the
// done state and from there into the output register. A text byte walks the slots in
// order through the single read port of the word-character memory: a slot that cannot
// match (unused, overlong, or with no segmentable prefix in front of it) is skipped in
// the slot state, a candidate slot is read and its characters are then compared one at
// a time in the compare state, and the walk stops at the first full match. The next
// beat is taken as soon as the result is in the output register, whether or not it
// has been taken yet. The word-character memory has no reset; read only slots written.
module dictionary_segmentation_check_core #(
	parameter int WORD_SLOTS   = dsc_pkg::WORD_SLOTS_DEF,
	parameter int MAX_WORD_LEN = dsc_pkg::MAX_WORD_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [3:0] word_slot,
	input  logic [3:0] char_index,
	input  logic [4:0] word_len,
	input  logic [7:0] char_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       segmentable
);

	localparam int SLOT_W = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
	localparam int K_W    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int DEPTH  = WORD_SLOTS * MAX_WORD_LEN;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	dsc_pkg::state_t state_q, state_d;

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_data_s1;
	logic [4:0]        len_q  [WORD_SLOTS];
	logic [7:0]        text_q [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] hist_q;

	logic [SLOT_W-1:0] slot_q;
	logic [K_W-1:0]    k_q;
	logic              flag_q;
	logic              text_item_q;
	logic              out_valid_q;
	logic              seg_q;

	logic              accept;
	logic              load_out;
	logic [4:0]        cur_len;
	logic [4:0]        cur_len_m1;
	logic              slot_elig;
	logic              last_slot;
	logic              last_k;
	logic              char_eq;
	logic              rd_en;
	logic [K_W-1:0]    rd_k;
	logic [ADDR_W-1:0] rd_addr;
	logic [SLOT_W-1:0] wr_slot;
	logic              wr_slot_ok;
	logic              wr_char_ok;
	logic [ADDR_W-1:0] wr_addr;

	assign cur_len    = len_q[slot_q];
	assign cur_len_m1 = cur_len - 5'd1;
	assign wr_slot    = SLOT_W'(word_slot);
	assign wr_slot_ok = 32'(word_slot) < WORD_SLOTS;
	assign wr_char_ok = 32'(char_index) < MAX_WORD_LEN;
	assign wr_addr    = ADDR_W'(wr_slot) * ADDR_W'(MAX_WORD_LEN) + ADDR_W'(K_W'(char_index));
	assign rd_addr    = ADDR_W'(slot_q) * ADDR_W'(MAX_WORD_LEN) + ADDR_W'(rd_k);

	// Datapath decode and handshake outputs
	always_comb begin
		in_ready  = (state_q == dsc_pkg::ST_IDLE);
		accept    = in_valid && in_ready;
		load_out  = (state_q == dsc_pkg::ST_DONE) && (!out_valid_q || out_ready);
		slot_elig = (cur_len != 5'd0) && (32'(cur_len) <= MAX_WORD_LEN)
			&& hist_q[K_W'(cur_len_m1)];
		last_slot = (32'(slot_q) == WORD_SLOTS - 1);
		last_k    = (k_q == K_W'(cur_len_m1));
		char_eq   = (rd_data_s1 == text_q[K_W'(cur_len_m1) - k_q]);
		rd_en     = 1'b0;
		rd_k      = '0;
		case (state_q)
			dsc_pkg::ST_SLOT: begin
				rd_en = slot_elig;
			end
			dsc_pkg::ST_CMP: begin
				rd_en = char_eq && !last_k;
				rd_k  = k_q + K_W'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dsc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (cmd == dsc_pkg::CMD_TEXT) ? dsc_pkg::ST_SLOT : dsc_pkg::ST_DONE;
				end
			end
			dsc_pkg::ST_SLOT: begin
				if (slot_elig) state_d = dsc_pkg::ST_CMP;
				else if (last_slot) state_d = dsc_pkg::ST_DONE;
			end
			dsc_pkg::ST_CMP: begin
				if (char_eq) begin
					if (last_k) state_d = dsc_pkg::ST_DONE;
				end else begin
					state_d = last_slot ? dsc_pkg::ST_DONE : dsc_pkg::ST_SLOT;
				end
			end
			dsc_pkg::ST_DONE: begin
				if (load_out) state_d = dsc_pkg::ST_IDLE;
			end
			default: begin
				state_d = dsc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == dsc_pkg::CMD_WRITE_CHAR && wr_slot_ok && wr_char_ok) begin
			mem[wr_addr] <= char_value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			seg_q       <= 1'b0;
			slot_q      <= '0;
			k_q         <= '0;
			flag_q      <= 1'b0;
			text_item_q <= 1'b0;
			hist_q      <= MAX_WORD_LEN'(1);
			for (int i = 0; i < WORD_SLOTS; i++) len_q[i] <= '0;
			for (int i = 0; i < MAX_WORD_LEN; i++) text_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				slot_q      <= '0;
				text_item_q <= (cmd == dsc_pkg::CMD_TEXT);
				flag_q      <= (cmd == dsc_pkg::CMD_START);
				case (dsc_pkg::cmd_t'(cmd))
					dsc_pkg::CMD_WRITE_CHAR: begin
						if (wr_slot_ok) len_q[wr_slot] <= word_len;
					end
					dsc_pkg::CMD_START: begin
						hist_q <= MAX_WORD_LEN'(1);
						for (int i = 0; i < MAX_WORD_LEN; i++) text_q[i] <= '0;
					end
					dsc_pkg::CMD_TEXT: begin
						text_q[0] <= char_value;
						for (int i = 1; i < MAX_WORD_LEN; i++) text_q[i] <= text_q[i-1];
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				dsc_pkg::ST_SLOT: begin
					if (slot_elig) k_q <= '0;
					else if (!last_slot) slot_q <= slot_q + SLOT_W'(1);
				end
				dsc_pkg::ST_CMP: begin
					if (char_eq) begin
						if (last_k) flag_q <= 1'b1;
						else k_q <= rd_k;
					end else if (!last_slot) begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
				seg_q       <= flag_q;
				// advance the prefix history by one text byte
				if (text_item_q) hist_q <= {hist_q[MAX_WORD_LEN-2:0], flag_q};
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign segmentable = seg_q;

	a_cmp_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsc_pkg::ST_CMP) |->
			($past(state_q) == dsc_pkg::ST_SLOT || $past(state_q) == dsc_pkg::ST_CMP))
		else $error("compare state entered without a slot read");

	a_start_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == dsc_pkg::CMD_START) |=> (flag_q && state_q == dsc_pkg::ST_DONE))
		else $error("start beat did not report the empty text as segmentable");

	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && seg_q == $past(flag_q) && in_ready))
		else $error("result not loaded into the output register");

endmodule
